// ----- rtl/mbs_pkg.sv -----
// Package for the memory BIST sequencer: phase codes, command codes, widths.
// No dependencies.
package mbs_pkg;
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FILL   = 3'd1,
    PH_VERIFY = 3'd2,
    PH_WSET   = 3'd3,
    PH_WREAD  = 3'd4,
    PH_WCLEAR = 3'd5,
    PH_BLOCK  = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BASE    = 2'd0,
    REG_WORDS   = 2'd1,
    REG_ENABLE  = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_e;

  localparam int unsigned NumTests = 5;
  localparam logic [31:0] Ones     = 32'hFFFF_FFFF;
  localparam logic [31:0] Fill3    = 32'hA5A5_A5A5;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef struct packed {
    logic        op;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  word_address;
    logic [31:0] write_data;
    logic        read_checked;
    logic        mismatch;
    logic [15:0] error_count;
    logic [2:0]  test_number;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;
endpackage

// ----- rtl/mbs_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Uses no package.
interface mbs_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mbs_engine.sv -----
// Test sequencing engine: state registers and command generation per transfer.
// Depends on mbs_pkg.
module mbs_engine #(
  parameter int unsigned AddrBits = 10,
  parameter int unsigned ColBits  = 5,
  parameter int unsigned RowBits  = 3,
  parameter int unsigned BankBits = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  mbs_pkg::in_item_t    item_i,
  input  logic [31:0]          base_i,
  input  logic [10:0]          words_i,
  input  logic [4:0]           enable_i,
  output mbs_pkg::out_item_t   result_o
);
  localparam int unsigned PW = AddrBits + 1;
  localparam int unsigned BW = AddrBits + 2;
  localparam logic [BW-1:0] NoiseRaw =
    BW'(((((64'd1 << ColBits) - 64'd1) << 2)
      | (((64'd1 << RowBits) - 64'd1) << (2 + ColBits))
      | (((64'd1 << BankBits) - 64'd1) << (2 + ColBits + RowBits))) & 64'hFFFF_FFFC);

  mbs_pkg::phase_e phase_q, phase_d;
  logic [2:0]    test_q, test_d;
  logic [PW-1:0] wp_q, wp_d, ip_q, ip_d, bp_q, bp_d;
  logic          pend_q, pend_d, skip_q, skip_d;
  logic [31:0]   exp_q, exp_d;
  logic [15:0]   err_q, err_d;

  logic [PW-1:0] n_words, n_mask;
  logic [4:0]    log_n;
  logic [PW-1:0] p_cnt;
  logic [BW-1:0] noise;
  logic          chk, mis;
  logic [1:0]    cmd;
  logic [PW-1:0] addr;
  logic [31:0]   wdata;

  function automatic int NumTestsRev();
    NumTestsRev = int'(mbs_pkg::NumTests) - 1;
  endfunction

  always_comb begin
    logic [PW-1:0] v;
    v = (words_i > 11'(PW'(1) << AddrBits)) ? (PW'(1) << AddrBits) : PW'(words_i);
    n_words = PW'(32);
    log_n   = 5'd5;
    for (int k = 6; k <= AddrBits; k++) begin
      if (v[k]) begin
        n_words = PW'(1) << k;
        log_n   = 5'(k);
      end
    end
    n_mask = n_words - PW'(1);
    p_cnt  = PW'(log_n) + PW'(1);
    noise  = NoiseRaw & ((BW'(n_words) << 2) - BW'(1));
  end

  function automatic logic [PW-1:0] walk(input logic [PW-1:0] idx);
    walk = (idx == '0) ? '0 : (PW'(1) << (idx - PW'(1)));
  endfunction

  always_comb begin
    logic        found;
    logic [31:0] pat;
    logic [PW-1:0] wm;
    logic [5:0]  s;
    logic [3:0]  k;
    logic [BW-1:0] a, bwa;
    logic [PW-1:0] bw;
    logic [31:0] d;
    phase_d = phase_q; test_d = test_q; wp_d = wp_q; ip_d = ip_q; bp_d = bp_q;
    pend_d = pend_q; skip_d = skip_q; exp_d = exp_q; err_d = err_q;
    chk = 1'b0; mis = 1'b0; cmd = mbs_pkg::CMD_IDLE; addr = '0; wdata = '0;
    found = 1'b0;
    wm  = wp_q & n_mask;
    case (test_q)
      3'd1:    pat = mbs_pkg::Ones;
      3'd3:    pat = mbs_pkg::Fill3;
      3'd4:    pat = ~(base_i + {{(29 - AddrBits){1'b0}}, wm, 2'b00});
      default: pat = '0;
    endcase
    s  = ip_q[5:0];
    k  = s[3:0];
    a  = {wp_q[AddrBits-1:0], 2'b00};
    bwa = ((~a) & noise) - BW'(60);
    bw = s[5] ? PW'(bwa[BW-1:2]) : wp_q;
    d  = k[0] ? 32'd0 : mbs_pkg::Ones;
    if (!item_i.op) begin
      err_d = '0; pend_d = 1'b0; exp_d = '0; skip_d = 1'b0; test_d = '0;
      phase_d = mbs_pkg::PH_DONE;
      for (int t = NumTestsRev(); t >= 0; t--) begin
        if (enable_i[t]) begin
          test_d = 3'(t); phase_d = mbs_pkg::PH_FILL; found = 1'b1;
        end
      end
      wp_d = '0; ip_d = '0; bp_d = '0;
    end else begin
      if (pend_q) begin
        if (!skip_q) begin
          chk = 1'b1;
          mis = item_i.read_data != exp_q;
          if (mis && err_q != mbs_pkg::CountMax) err_d = err_q + 16'd1;
        end
        pend_d = 1'b0; skip_d = 1'b0;
      end
      case (phase_q)
        mbs_pkg::PH_FILL: begin
          cmd = mbs_pkg::CMD_WRITE; addr = wm; wdata = pat;
          if (wp_q + PW'(1) >= n_words) begin
            wp_d = '0; ip_d = '0; bp_d = '0;
            phase_d = (test_q == 3'd2) ? mbs_pkg::PH_WSET :
                      (test_q == 3'd3) ? mbs_pkg::PH_BLOCK : mbs_pkg::PH_VERIFY;
          end else wp_d = wp_q + PW'(1);
        end
        mbs_pkg::PH_VERIFY: begin
          cmd = mbs_pkg::CMD_READ; addr = wm;
          pend_d = 1'b1; exp_d = pat; skip_d = 1'b0;
          if (wp_q + PW'(1) >= n_words) found = 1'b1;
          else wp_d = wp_q + PW'(1);
        end
        mbs_pkg::PH_WSET: begin
          cmd = mbs_pkg::CMD_WRITE; addr = walk(wp_q) & n_mask; wdata = mbs_pkg::Ones;
          ip_d = '0; phase_d = mbs_pkg::PH_WREAD;
        end
        mbs_pkg::PH_WREAD: begin
          cmd = mbs_pkg::CMD_READ; addr = walk(ip_q) & n_mask;
          pend_d = 1'b1; exp_d = '0; skip_d = ip_q == wp_q;
          if (ip_q + PW'(1) >= p_cnt) phase_d = mbs_pkg::PH_WCLEAR;
          else ip_d = ip_q + PW'(1);
        end
        mbs_pkg::PH_WCLEAR: begin
          cmd = mbs_pkg::CMD_WRITE; addr = walk(wp_q) & n_mask;
          if (wp_q + PW'(1) >= p_cnt) found = 1'b1;
          else begin
            wp_d = wp_q + PW'(1); phase_d = mbs_pkg::PH_WSET;
          end
        end
        mbs_pkg::PH_BLOCK: begin
          addr = (bw + PW'(k)) & n_mask;
          if (s[4]) begin
            cmd = mbs_pkg::CMD_READ; pend_d = 1'b1; exp_d = d; skip_d = 1'b0;
          end else begin
            cmd = mbs_pkg::CMD_WRITE; wdata = d;
          end
          if (s == 6'd63) begin
            if (bp_q + PW'(1) >= (n_words >> 5)) found = 1'b1;
            else begin
              bp_d = bp_q + PW'(1);
              bwa  = (a & noise) + BW'(64);
              wp_d = PW'(bwa[BW-1:2]) & n_mask;
              ip_d = '0;
            end
          end else ip_d = PW'(s) + PW'(1);
        end
        mbs_pkg::PH_DONE: cmd = mbs_pkg::CMD_DONE;
        default: ;
      endcase
      if (found) begin
        found   = 1'b0;
        phase_d = mbs_pkg::PH_DONE;
        for (int t = NumTestsRev(); t >= 0; t--) begin
          if (enable_i[t] && 3'(t) > test_q) begin
            test_d = 3'(t); phase_d = mbs_pkg::PH_FILL; found = 1'b1;
          end
        end
        if (found) begin
          wp_d = '0; ip_d = '0; bp_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mbs_pkg::PH_IDLE; test_q <= '0; wp_q <= '0; ip_q <= '0; bp_q <= '0;
      pend_q <= 1'b0; skip_q <= 1'b0; exp_q <= '0; err_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; test_q <= test_d; wp_q <= wp_d; ip_q <= ip_d; bp_q <= bp_d;
      pend_q <= pend_d; skip_q <= skip_d; exp_q <= exp_d; err_q <= err_d;
    end
  end

  always_comb begin
    result_o.command      = cmd;
    result_o.word_address = 10'(addr);
    result_o.write_data   = wdata;
    result_o.read_checked = chk;
    result_o.mismatch     = mis;
    result_o.error_count  = err_d;
    result_o.test_number  = test_d;
  end
endmodule

// ----- rtl/mbs_cfg_regs.sv -----
// Configuration register file for the BIST sequencer.
// Depends on mbs_pkg and mbs_if.
module mbs_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbs_if.sink          cfg,
  output logic [31:0]  base_o,
  output logic [10:0]  words_o,
  output logic [4:0]   enable_o
);
  logic [31:0] base_q;
  logic [10:0] words_q;
  logic [4:0]  enable_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; words_q <= 11'd1024; enable_q <= 5'd31;
    end else if (cfg.valid) begin
      case (mbs_pkg::reg_e'(cfg.payload.index))
        mbs_pkg::REG_BASE:   base_q   <= cfg.payload.data;
        mbs_pkg::REG_WORDS:  words_q  <= cfg.payload.data[10:0];
        mbs_pkg::REG_ENABLE: enable_q <= cfg.payload.data[4:0];
        default: ;
      endcase
    end
  end

  assign base_o   = base_q;
  assign words_o  = words_q;
  assign enable_o = enable_q;
endmodule

// ----- rtl/memory_bist_sequencer_unit.sv -----
// Top level of the memory BIST sequencer: configuration registers, engine, result register.
// Depends on mbs_pkg, mbs_if, mbs_cfg_regs and mbs_engine.
//
//  channel   direction  payload
//  in_ch     sink       op, read_data
//  out_ch    source     command, word_address, write_data, read_checked,
//                       mismatch, error_count, test_number
//  cfg_ch    sink       index, data
//
// One transfer in gives one transfer out; a new item is taken in every cycle while the output is not stalled.
// The result register after the engine logic holds each result; it is offered in the cycle after its input is taken.
// Reset sets the phase to idle and loads the register defaults.
// Input is taken whenever the result register is empty or being drained.
module memory_bist_sequencer_unit #(
  parameter int unsigned ADDR_BITS = 10,
  parameter int unsigned COL_BITS  = 5,
  parameter int unsigned ROW_BITS  = 3,
  parameter int unsigned BANK_BITS = 2
) (
  input logic clk_i,
  input logic rst_ni,
  mbs_if.sink   in_ch,
  mbs_if.source out_ch,
  mbs_if.sink   cfg_ch
);
  logic [31:0] base;
  logic [10:0] words;
  logic [4:0]  enable;
  logic        step;
  logic        full_q;
  mbs_pkg::out_item_t res, res_q;

  mbs_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg(cfg_ch), .base_o(base), .words_o(words), .enable_o(enable)
  );

  assign in_ch.ready = !full_q || out_ch.ready;
  assign step = in_ch.valid && in_ch.ready;

  mbs_engine #(
    .AddrBits(ADDR_BITS), .ColBits(COL_BITS), .RowBits(ROW_BITS), .BankBits(BANK_BITS)
  ) u_engine (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_ch.payload),
    .base_i(base), .words_i(words), .enable_i(enable), .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (step) full_q <= 1'b1;
    else if (out_ch.ready) full_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_ch.valid   = full_q;
  assign out_ch.payload = res_q;

  a_mis_needs_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (!out_ch.payload.mismatch || out_ch.payload.read_checked))
    else $error("mismatch without check");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.payload))
    else $error("result changed while stalled");
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.payload.command == mbs_pkg::CMD_IDLE)
      |-> out_ch.payload.write_data == '0)
    else $error("idle result carries data");
endmodule
